### rtl/core/jsu_pkg.sv
// jsu_pkg: shared types, character codes and helper functions for the json string unescaper
// no dependencies; used by jsu_decode, jsu_outq and json_string_unescape_utf8
package jsu_pkg;

   localparam int RES_MAX   = 4;
   localparam int RES_IDX_W = $clog2(RES_MAX);
   localparam int RES_CNT_W = $clog2(RES_MAX + 1);

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;

   localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
   localparam logic [20:0] SUPP_BASE     = 21'h10000;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_done;
      logic       decode_error;
   } rsp_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]  count;
      rsp_type [RES_MAX-1:0] items;
   } step_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]     len;
      logic [RES_MAX-1:0][7:0] bytes;
   } utf8_type;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if (c >= 8'h30 && c <= 8'h39)      v = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
      else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
      return v;
   endfunction

   function automatic logic [7:0] escape_byte(input logic [7:0] c);
      logic [7:0] v;
      case (c)
         CHAR_B:  v = 8'h08;
         CHAR_F:  v = 8'h0C;
         CHAR_N:  v = 8'h0A;
         CHAR_R:  v = 8'h0D;
         CHAR_T:  v = 8'h09;
         default: v = c;
      endcase
      return v;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] u);
      utf8_type r;
      r = '0;
      if (u < 21'h80) begin
         r.len      = RES_CNT_W'(1);
         r.bytes[0] = u[7:0];
      end else if (u < 21'h800) begin
         r.len      = RES_CNT_W'(2);
         r.bytes[0] = {3'b110, u[10:6]};
         r.bytes[1] = {2'b10, u[5:0]};
      end else if (u < SUPP_BASE) begin
         r.len      = RES_CNT_W'(3);
         r.bytes[0] = {4'b1110, u[15:12]};
         r.bytes[1] = {2'b10, u[11:6]};
         r.bytes[2] = {2'b10, u[5:0]};
      end else begin
         r.len      = RES_CNT_W'(4);
         r.bytes[0] = {5'b11110, u[20:18]};
         r.bytes[1] = {2'b10, u[17:12]};
         r.bytes[2] = {2'b10, u[11:6]};
         r.bytes[3] = {2'b10, u[5:0]};
      end
      return r;
   endfunction

endpackage

### rtl/core/jsu_decode.sv
// jsu_decode: escape and surrogate state machine, one input word per step, up to four results
// depends on jsu_pkg
module jsu_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  jsu_pkg::req_type in_word,
   output jsu_pkg::step_type result
);

   typedef enum logic [2:0] {
      MODE_PLAIN,
      MODE_ESC,
      MODE_HEX1,
      MODE_AFTER_HIGH,
      MODE_HIGH_BS,
      MODE_HEX2,
      MODE_SKIP,
      MODE_SKIP_ESC
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  held_ff, held_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic [7:0]  c;
   logic        is_end;
   logic [4:0]  hv;
   logic [15:0] acc_new;
   logic [15:0] hs;
   logic        u_en;
   logic [20:0] u_val;
   logic        x_en;
   jsu_pkg::rsp_type  x_word;
   jsu_pkg::utf8_type utf;
   logic [jsu_pkg::RES_CNT_W-1:0] ulen;

   assign c       = in_word.text_byte;
   assign is_end  = in_word.text_end;
   assign hv      = jsu_pkg::hex_value(c);
   assign acc_new = {acc_ff[11:0], hv[3:0]};
   assign hs      = {jsu_pkg::SURR_HIGH_TAG, held_ff};

   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      held_in = held_ff;
      cnt_in  = cnt_ff;
      u_en    = 1'b0;
      u_val   = 21'(hs);
      x_en    = 1'b0;
      x_word  = '0;
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (is_end || c == jsu_pkg::CHAR_QUOTE) begin
               x_en               = 1'b1;
               x_word.string_done = 1'b1;
            end else if (c == jsu_pkg::CHAR_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               x_en              = 1'b1;
               x_word.out_byte   = c;
               x_word.byte_valid = 1'b1;
            end
         end
         MODE_ESC: begin
            if (is_end) begin
               x_en                = 1'b1;
               x_word.string_done  = 1'b1;
               x_word.decode_error = 1'b1;
               mode_in             = MODE_PLAIN;
            end else if (c == jsu_pkg::CHAR_U) begin
               mode_in = MODE_HEX1;
               acc_in  = '0;
               cnt_in  = '0;
            end else begin
               x_en              = 1'b1;
               x_word.out_byte   = jsu_pkg::escape_byte(c);
               x_word.byte_valid = 1'b1;
               mode_in           = MODE_PLAIN;
            end
         end
         MODE_HEX1, MODE_HEX2: begin
            if (is_end) begin
               u_en                = (mode_ff == MODE_HEX2);
               x_en                = 1'b1;
               x_word.string_done  = 1'b1;
               x_word.decode_error = 1'b1;
               mode_in             = MODE_PLAIN;
               acc_in              = '0;
               held_in             = '0;
               cnt_in              = '0;
            end else if (hv[4]) begin
               u_en                = (mode_ff == MODE_HEX2);
               x_en                = 1'b1;
               x_word.decode_error = 1'b1;
               mode_in             = MODE_SKIP;
               acc_in              = '0;
               held_in             = '0;
               cnt_in              = '0;
            end else if (cnt_ff != 2'd3) begin
               acc_in = acc_new;
               cnt_in = cnt_ff + 2'd1;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               if (mode_ff == MODE_HEX1) begin
                  if (acc_new[15:10] == jsu_pkg::SURR_HIGH_TAG) begin
                     held_in = acc_new[9:0];
                     mode_in = MODE_AFTER_HIGH;
                  end else begin
                     u_en    = 1'b1;
                     u_val   = 21'(acc_new);
                     mode_in = MODE_PLAIN;
                  end
               end else begin
                  u_en = 1'b1;
                  if (acc_new[15:10] == jsu_pkg::SURR_LOW_TAG) begin
                     u_val = jsu_pkg::SUPP_BASE + 21'({held_ff, acc_new[9:0]});
                  end
                  held_in = '0;
                  mode_in = MODE_PLAIN;
               end
            end
         end
         MODE_AFTER_HIGH: begin
            if (is_end) begin
               u_en               = 1'b1;
               x_en               = 1'b1;
               x_word.string_done = 1'b1;
               mode_in            = MODE_PLAIN;
               held_in            = '0;
            end else if (c == jsu_pkg::CHAR_BSLASH) begin
               mode_in = MODE_HIGH_BS;
            end else begin
               u_en    = 1'b1;
               x_en    = 1'b1;
               held_in = '0;
               mode_in = MODE_PLAIN;
               if (c == jsu_pkg::CHAR_QUOTE) begin
                  x_word.string_done = 1'b1;
               end else begin
                  x_word.out_byte   = c;
                  x_word.byte_valid = 1'b1;
               end
            end
         end
         MODE_HIGH_BS: begin
            if (is_end) begin
               u_en                = 1'b1;
               x_en                = 1'b1;
               x_word.string_done  = 1'b1;
               x_word.decode_error = 1'b1;
               mode_in             = MODE_PLAIN;
               held_in             = '0;
            end else if (c == jsu_pkg::CHAR_U) begin
               mode_in = MODE_HEX2;
               acc_in  = '0;
               cnt_in  = '0;
            end else begin
               u_en              = 1'b1;
               x_en              = 1'b1;
               x_word.out_byte   = jsu_pkg::escape_byte(c);
               x_word.byte_valid = 1'b1;
               held_in           = '0;
               mode_in           = MODE_PLAIN;
            end
         end
         MODE_SKIP: begin
            if (is_end || c == jsu_pkg::CHAR_QUOTE) begin
               x_en               = 1'b1;
               x_word.string_done = 1'b1;
               mode_in            = MODE_PLAIN;
            end else if (c == jsu_pkg::CHAR_BSLASH) begin
               mode_in = MODE_SKIP_ESC;
            end
         end
         MODE_SKIP_ESC: begin
            if (is_end) begin
               x_en               = 1'b1;
               x_word.string_done = 1'b1;
               mode_in            = MODE_PLAIN;
            end else begin
               mode_in = MODE_SKIP;
            end
         end
      endcase
   end

   // utf-8 bytes first, then at most one trailing word
   assign utf  = jsu_pkg::utf8_encode(u_val);
   assign ulen = u_en ? utf.len : '0;

   always_comb begin
      result.count = ulen + jsu_pkg::RES_CNT_W'(x_en);
      for (int i = 0; i < jsu_pkg::RES_MAX; i++) begin
         result.items[i] = '0;
         if (jsu_pkg::RES_CNT_W'(i) < ulen) begin
            result.items[i].out_byte   = utf.bytes[i];
            result.items[i].byte_valid = 1'b1;
         end else if (jsu_pkg::RES_CNT_W'(i) == ulen && x_en) begin
            result.items[i] = x_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         acc_ff  <= '0;
         held_ff <= '0;
         cnt_ff  <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         held_ff <= held_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

### rtl/core/jsu_outq.sv
// jsu_outq: four-word result queue, takes up to four words at once and gives one per cycle
// while rsp_ready is high; depends on jsu_pkg
module jsu_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  jsu_pkg::step_type             push_data,
   output logic [jsu_pkg::RES_CNT_W-1:0] space,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output jsu_pkg::rsp_type              rsp_data
);

   jsu_pkg::rsp_type q_ff [jsu_pkg::RES_MAX];
   logic [jsu_pkg::RES_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::RES_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::RES_CNT_W-1:0] count_ff, count_in;
   logic [jsu_pkg::RES_CNT_W-1:0] push_cnt;
   logic                          pop;

   assign pop       = rsp_valid && rsp_ready;
   assign push_cnt  = push ? push_data.count : '0;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign space     = jsu_pkg::RES_CNT_W'(jsu_pkg::RES_MAX) - count_ff
                      + jsu_pkg::RES_CNT_W'(pop);

   assign wr_ptr_in = wr_ptr_ff + push_cnt[jsu_pkg::RES_IDX_W-1:0];
   assign rd_ptr_in = rd_ptr_ff + jsu_pkg::RES_IDX_W'(pop);
   assign count_in  = count_ff + push_cnt - jsu_pkg::RES_CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < jsu_pkg::RES_MAX; i++) begin
         if (jsu_pkg::RES_CNT_W'(i) < push_cnt) begin
            q_ff[wr_ptr_ff + jsu_pkg::RES_IDX_W'(i)] <= push_data.items[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/json_string_unescape_utf8.sv
// json_string_unescape_utf8: top level of the json string unescaper with utf-8 output
// depends on jsu_pkg, jsu_decode and jsu_outq
//
// usage: the req channel takes one raw byte of a json string body per word (text_end set
// marks end of text, the byte then ignored). the rsp channel gives the decoded words: a byte
// with byte_valid, or a marker word with string_done and/or decode_error clear of data.
// a word sits in an input register, the decoder turns it combinationally into zero to four
// result words and, when it steps, writes them all into a four-word result queue.
// the first result word passes through the input register and then the result queue.
// throughput: one request word per cycle while each gives at most one result and rsp_ready
// stays high; the result queue drains one word per cycle while rsp_ready is high, so a code
// point of several utf-8 bytes holds the input. the decoder steps only when the queue has
// room for all of its words. a stalled rsp side fills the queue and then the input register;
// req_ready falls and nothing is lost or dropped.
// reset empties the input register and the queue, and returns the decoder to plain content mode.
module json_string_unescape_utf8 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  jsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jsu_pkg::rsp_type rsp_data
);

   jsu_pkg::req_type              in_ff;
   logic                          in_valid_ff, in_valid_in;
   logic                          step;
   jsu_pkg::step_type             dec_out;
   logic [jsu_pkg::RES_CNT_W-1:0] space;

   assign step        = in_valid_ff && (dec_out.count <= space);
   assign req_ready   = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   jsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_word (in_ff),
      .result  (dec_out)
   );

   jsu_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (dec_out),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      step && in_ff.text_end |-> dec_out.count != '0)
      else $error("end of text stepped without a result word");

   a_done_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.string_done || rsp_data.decode_error) |-> !rsp_data.byte_valid)
      else $error("marker word also carries a byte");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      step |-> dec_out.count <= space)
      else $error("result queue overflow");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_ff))
      else $error("input register lost a pending word");
`endif

endmodule
